// ===== sv/uutp_pkg.sv =====
// ---------------------------------------------------------------------------
// uutp_pkg
// Types, character codes and helper functions for the lenient UUID text
// parser.
// ---------------------------------------------------------------------------
package uutp_pkg;

   localparam int CountWidth = 6;
   localparam int GroupIdxWidth = 3;
   localparam int GroupValWidth = 63;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG = 2'd1;
   localparam logic [1:0] ERR_INVALID  = 2'd2;

   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;

   localparam logic [GroupIdxWidth-1:0] LAST_GROUP = 3'd4;

   typedef struct packed {
      logic [CountWidth-1:0]    char_count;
      logic [GroupIdxWidth-1:0] group_index;
      logic [GroupValWidth-1:0] group_value;
      logic                     group_fresh;
      logic                     group_has_digit;
      logic [63:0]              packed_high;
      logic [63:0]              packed_low;
      logic                     invalid_seen;
   } parse_state_type;

   typedef struct packed {
      logic [63:0] uuid_high;
      logic [63:0] uuid_low;
      logic [1:0]  error_code;
   } parse_result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] digit;
   } hex_type;

   localparam parse_state_type STATE_RESET = '{
      char_count:      '0,
      group_index:     '0,
      group_value:     '0,
      group_fresh:     1'b1,
      group_has_digit: 1'b0,
      packed_high:     '0,
      packed_low:      '0,
      invalid_seen:    1'b0
   };

   function automatic hex_type decode_hex(input logic [7:0] c);
      hex_type h;
      h.is_hex = 1'b1;
      h.digit  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.digit = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.digit = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.digit = 4'(c - 8'h37);
      end else begin
         h.is_hex = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== sv/uutp_req_if.sv =====
// ---------------------------------------------------------------------------
// uutp_req_if
// Request channel: at most one text character per transfer with a final flag.
// ---------------------------------------------------------------------------
interface uutp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       has_char;
   logic       last;

   modport source (output valid, output char_code, output has_char, output last,
                   input ready);
   modport sink   (input valid, input char_code, input has_char, input last,
                   output ready);
endinterface

// ===== sv/uutp_rsp_if.sv =====
// ---------------------------------------------------------------------------
// uutp_rsp_if
// Response channel: parsed UUID halves and an error code.
// ---------------------------------------------------------------------------
interface uutp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] uuid_high;
   logic [63:0] uuid_low;
   logic [1:0]  error_code;

   modport source (output valid, output uuid_high, output uuid_low, output error_code,
                   input ready);
   modport sink   (input valid, input uuid_high, input uuid_low, input error_code,
                   output ready);
endinterface

// ===== sv/uutp_step.sv =====
// ---------------------------------------------------------------------------
// uutp_step
// Next-state and result logic for one request of the UUID text parser.
// ---------------------------------------------------------------------------
module uutp_step #(
   parameter int MAX_TEXT_LENGTH = 36
) (
   input  uutp_pkg::parse_state_type  cur_state,
   input  logic [7:0]                 char_code,
   input  logic                       has_char,
   input  logic                       last,
   output uutp_pkg::parse_state_type  nxt_state,
   output uutp_pkg::parse_result_type result
);
   import uutp_pkg::*;

   localparam logic [CountWidth-1:0] MaxLen = CountWidth'(MAX_TEXT_LENGTH);

   parse_state_type st;
   hex_type         hx;
   logic            fin_invalid;
   logic [1:0]      err;

   assign hx = decode_hex(char_code);

   always_comb begin
      st = cur_state;
      if (has_char) begin
         if (st.char_count <= MaxLen) begin
            st.char_count = CountWidth'(st.char_count + 1'b1);
         end
         if (!st.invalid_seen) begin
            if (char_code == CHAR_DASH) begin
               if (st.group_index >= LAST_GROUP || !st.group_has_digit) begin
                  st.invalid_seen = 1'b1;
               end else begin
                  unique case (st.group_index[1:0])
                     2'd0: st.packed_high[63:32] = st.group_value[31:0];
                     2'd1: st.packed_high[31:16] = st.group_value[15:0];
                     2'd2: st.packed_high[15:0]  = st.group_value[15:0];
                     default: st.packed_low[63:48] = st.group_value[15:0];
                  endcase
                  st.group_index     = GroupIdxWidth'(st.group_index + 1'b1);
                  st.group_value     = '0;
                  st.group_fresh     = 1'b1;
                  st.group_has_digit = 1'b0;
               end
            end else if (char_code == CHAR_PLUS) begin
               if (st.group_fresh) st.group_fresh = 1'b0;
               else st.invalid_seen = 1'b1;
            end else if (hx.is_hex) begin
               st.group_fresh     = 1'b0;
               st.group_has_digit = 1'b1;
               // value*16+d stays below 2^63 exactly when the top nibble is clear
               if (st.group_value[62:59] != 4'd0) begin
                  st.invalid_seen = 1'b1;
               end else begin
                  st.group_value = {st.group_value[58:0], hx.digit};
               end
            end else begin
               st.invalid_seen = 1'b1;
            end
         end
      end

      fin_invalid = st.invalid_seen || st.group_index != LAST_GROUP || !st.group_has_digit;

      priority if (st.char_count > MaxLen) begin
         err = ERR_TOO_LONG;
      end else if (fin_invalid) begin
         err = ERR_INVALID;
      end else begin
         err = ERR_OK;
      end

      result.error_code = err;
      result.uuid_high  = (err == ERR_OK) ? st.packed_high : 64'd0;
      result.uuid_low   = (err == ERR_OK) ? {st.packed_low[63:48], st.group_value[47:0]}
                                          : 64'd0;

      nxt_state = last ? STATE_RESET : st;
   end

endmodule

// ===== sv/uuid_text_parser_lenient.sv =====
// ---------------------------------------------------------------------------
// uuid_text_parser_lenient
// Lenient UUID text parser: five dash-separated hex groups to 128 bits.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one character per request (char_code, has_char) and a last
//   flag that closes the text. A request with has_char low and last low
//   changes nothing. rsp carries one response per text, issued for the
//   request with last set: uuid_high, uuid_low and error_code (0 ok,
//   1 too long, 2 invalid); both halves are zero on any error.
//   A request is held in an input register, decoded by the combinational
//   step logic and its response lands in the output register.
//   Throughput: one request per cycle while rsp is not stalled, set by
//   the single decode step between the input and output registers.
//   A stalled response holds the output register; the input register keeps
//   taking one request, then req.ready drops until rsp.ready returns.
//   Reset clears both registers' valid flags and the parse state; a text
//   in flight is dropped.
// ---------------------------------------------------------------------------
module uuid_text_parser_lenient #(
   parameter int MAX_TEXT_LENGTH = 36
) (
   input logic        clock,
   input logic        reset,
   uutp_req_if.sink   req,
   uutp_rsp_if.source rsp
);
   import uutp_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_has_ff;
   logic       in_last_ff;

   // parse state and output register
   parse_state_type  state_ff, state_in;
   parse_result_type step_result;
   parse_result_type out_ff;
   logic             out_valid_ff, out_valid_in;

   logic in_take;
   logic step_go;
   logic out_free;

   assign out_free = !out_valid_ff || rsp.ready;
   assign step_go  = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || step_go;
   assign in_take  = req.valid && req.ready;

   uutp_step #(
      .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
   ) u_step (
      .cur_state (state_ff),
      .char_code (in_char_ff),
      .has_char  (in_has_ff),
      .last      (in_last_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (step_go) in_valid_in = 1'b0;
      if (in_take) in_valid_in = 1'b1;

      out_valid_in = out_valid_ff;
      if (rsp.ready) out_valid_in = 1'b0;
      if (step_go && in_last_ff) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_go) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_char_ff <= req.char_code;
         in_has_ff  <= req.has_char;
         in_last_ff <= req.last;
      end
      if (step_go && in_last_ff) out_ff <= step_result;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.uuid_high  = out_ff.uuid_high;
   assign rsp.uuid_low   = out_ff.uuid_low;
   assign rsp.error_code = out_ff.error_code;

   // an error response never carries a value
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.error_code != ERR_OK |-> rsp.uuid_high == 64'd0 &&
         rsp.uuid_low == 64'd0)
      else $error("error response with nonzero halves");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.error_code == ERR_OK || rsp.error_code == ERR_TOO_LONG ||
         rsp.error_code == ERR_INVALID)
      else $error("undefined error code");

   // closing a text returns the parser to its start state
   assert property (@(posedge clock) disable iff (reset)
      step_go && in_last_ff |=> state_ff == STATE_RESET)
      else $error("parse state not cleared after last request");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.char_count <= CountWidth'(MAX_TEXT_LENGTH + 1))
      else $error("character count beyond saturation");

   // a last request that advances always produces a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      step_go && in_last_ff |=> rsp.valid)
      else $error("response lost for last request");

endmodule
